FILE: rtl/core/pwmook_pkg.sv
`timescale 1ns / 1ps

package pwmook_pkg;

  localparam int unsigned DUR_W   = 24;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned OUT_W   = 64;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

  localparam logic [TIME_W-1:0]  SHORT_TIME_RST      = 16'd600;
  localparam logic [TIME_W-1:0]  LONG_TIME_RST       = 16'd4000;
  localparam logic [TIME_W-1:0]  PULSE_TOLERANCE_RST = 16'd300;
  localparam logic [TIME_W-1:0]  GAP_TIME_RST        = 16'd30000;
  localparam logic [TIME_W-1:0]  GAP_TOLERANCE_RST   = 16'd1500;
  localparam logic [COUNT_W-1:0] FRAME_BITS_RST      = 7'd18;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHORT_TIME      = 3'd0,
    CFG_LONG_TIME       = 3'd1,
    CFG_PULSE_TOLERANCE = 3'd2,
    CFG_GAP_TIME        = 3'd3,
    CFG_GAP_TOLERANCE   = 3'd4,
    CFG_FRAME_BITS      = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } phase_t;

  typedef struct packed {
    logic lh_long;
    logic lh_short;
    logic dur_short;
    logic dur_long;
    logic dur_gap;
  } match_t;

  // |v - nominal| < tol, strict, so a zero tolerance never matches
  function automatic logic near(input logic [DUR_W-1:0] v,
                                input logic [TIME_W-1:0] nominal,
                                input logic [TIME_W-1:0] tol);
    logic [DUR_W-1:0] n_ext;
    logic [DUR_W-1:0] diff;
    n_ext = {{(DUR_W-TIME_W){1'b0}}, nominal};
    diff  = (v > n_ext) ? (v - n_ext) : (n_ext - v);
    return diff < {{(DUR_W-TIME_W){1'b0}}, tol};
  endfunction

endpackage

FILE: rtl/core/pwmook_in_if.sv
`timescale 1ns / 1ps

interface pwmook_in_if;
  logic                           valid;
  logic                           ready;
  logic                           level;
  logic [pwmook_pkg::DUR_W-1:0]   duration;

  modport source (output valid, output level, output duration, input ready);
  modport sink   (input valid, input level, input duration, output ready);
endinterface

FILE: rtl/core/pwmook_out_if.sv
`timescale 1ns / 1ps

interface pwmook_out_if;
  logic                           valid;
  logic                           ready;
  logic [pwmook_pkg::OUT_W-1:0]   code;

  modport source (output valid, output code, input ready);
  modport sink   (input valid, input code, output ready);
endinterface

FILE: rtl/core/pwmook_classify.sv
`timescale 1ns / 1ps

module pwmook_classify (
  input  logic [pwmook_pkg::TIME_W-1:0] short_time,
  input  logic [pwmook_pkg::TIME_W-1:0] long_time,
  input  logic [pwmook_pkg::TIME_W-1:0] pulse_tolerance,
  input  logic [pwmook_pkg::TIME_W-1:0] gap_time,
  input  logic [pwmook_pkg::TIME_W-1:0] gap_tolerance,
  input  logic [pwmook_pkg::DUR_W-1:0]  last_high,
  input  logic [pwmook_pkg::DUR_W-1:0]  duration,
  output pwmook_pkg::match_t            match
);

  // five independent window compares, all in parallel
  always_comb begin
    match.lh_long   = pwmook_pkg::near(last_high, long_time, pulse_tolerance);
    match.lh_short  = pwmook_pkg::near(last_high, short_time, pulse_tolerance);
    match.dur_short = pwmook_pkg::near(duration, short_time, pulse_tolerance);
    match.dur_long  = pwmook_pkg::near(duration, long_time, pulse_tolerance);
    match.dur_gap   = pwmook_pkg::near(duration, gap_time, gap_tolerance);
  end

endmodule

FILE: rtl/core/pwm_ook_remote_code_decoder.sv
`timescale 1ns / 1ps

// Pulse-width OOK remote decoder. Takes one (level, duration) pulse per cycle
// and issues the received code when a closing gap ends a frame of exactly
// frame_bits bits. A pulse is registered on acceptance and classified from
// the input register against the window compares; the code from a closing
// gap pulse is then written into the output register, which presents it;
// throughput is one pulse per cycle, limited only by the output register being
// held by a stalled sink.
// Only the last CODE_WIDTH bits of a frame appear in code, zero-extended to
// 64 bits. Registers are written through the cfg port and must be changed
// only while no pulses are in flight.
module pwm_ook_remote_code_decoder #(
  parameter int unsigned CODE_WIDTH = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  pwmook_in_if.sink                          in_ch,
  pwmook_out_if.source                       out_ch,
  input  logic                               cfg_we,
  input  logic [pwmook_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pwmook_pkg::TIME_W-1:0]      cfg_wdata
);

  localparam int unsigned CW = pwmook_pkg::COUNT_W;

  // configuration
  logic [pwmook_pkg::TIME_W-1:0] short_time_r;
  logic [pwmook_pkg::TIME_W-1:0] long_time_r;
  logic [pwmook_pkg::TIME_W-1:0] pulse_tol_r;
  logic [pwmook_pkg::TIME_W-1:0] gap_time_r;
  logic [pwmook_pkg::TIME_W-1:0] gap_tol_r;
  logic [CW-1:0]                 frame_bits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_time_r <= pwmook_pkg::SHORT_TIME_RST;
      long_time_r  <= pwmook_pkg::LONG_TIME_RST;
      pulse_tol_r  <= pwmook_pkg::PULSE_TOLERANCE_RST;
      gap_time_r   <= pwmook_pkg::GAP_TIME_RST;
      gap_tol_r    <= pwmook_pkg::GAP_TOLERANCE_RST;
      frame_bits_r <= pwmook_pkg::FRAME_BITS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pwmook_pkg::CFG_SHORT_TIME:      short_time_r <= cfg_wdata;
        pwmook_pkg::CFG_LONG_TIME:       long_time_r  <= cfg_wdata;
        pwmook_pkg::CFG_PULSE_TOLERANCE: pulse_tol_r  <= cfg_wdata;
        pwmook_pkg::CFG_GAP_TIME:        gap_time_r   <= cfg_wdata;
        pwmook_pkg::CFG_GAP_TOLERANCE:   gap_tol_r    <= cfg_wdata;
        pwmook_pkg::CFG_FRAME_BITS:      frame_bits_r <= cfg_wdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                           in_valid_r;
  logic                           level_r;
  logic [pwmook_pkg::DUR_W-1:0]   dur_r;
  logic                           advance;
  logic                           in_fire;
  logic                           work;

  logic                           out_valid_r;
  logic [CODE_WIDTH-1:0]          code_r;

  assign advance      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !in_valid_r || advance;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign work         = in_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_fire) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      level_r <= in_ch.level;
      dur_r   <= in_ch.duration;
    end
  end

  // decoder state
  pwmook_pkg::phase_t             phase_r, phase_nxt;
  logic [pwmook_pkg::DUR_W-1:0]   last_high_r, last_high_nxt;
  logic [CODE_WIDTH-1:0]          shift_r, shift_nxt;
  logic [CW-1:0]                  count_r, count_nxt;
  logic                           emit;
  pwmook_pkg::match_t             match;

  pwmook_classify u_classify (
    .short_time      (short_time_r),
    .long_time       (long_time_r),
    .pulse_tolerance (pulse_tol_r),
    .gap_time        (gap_time_r),
    .gap_tolerance   (gap_tol_r),
    .last_high       (last_high_r),
    .duration        (dur_r),
    .match           (match)
  );

  logic [CW:0]           cnt_plus1;
  logic [CW:0]           cnt_plus2;
  logic [CW-1:0]         cnt_sat1;
  logic [CW-1:0]         cnt_sat2;
  logic [CW-1:0]         gap_count;
  logic [CODE_WIDTH-1:0] gap_shift;

  always_comb begin
    cnt_plus1 = {1'b0, count_r} + {{CW{1'b0}}, 1'b1};
    cnt_plus2 = {1'b0, count_r} + {{(CW-1){1'b0}}, 2'd2};
    cnt_sat1  = cnt_plus1[CW] || (cnt_plus1[CW-1:0] > pwmook_pkg::COUNT_MAX) ?
                pwmook_pkg::COUNT_MAX : cnt_plus1[CW-1:0];
    cnt_sat2  = cnt_plus2[CW] ? pwmook_pkg::COUNT_MAX : cnt_plus2[CW-1:0];

    // closing gap: the last high may give a 1, a 0, both (1 then 0) or none
    if (match.lh_long && match.lh_short) begin
      gap_shift = {shift_r[CODE_WIDTH-3:0], 2'b10};
      gap_count = cnt_sat2;
    end else if (match.lh_long) begin
      gap_shift = {shift_r[CODE_WIDTH-2:0], 1'b1};
      gap_count = cnt_sat1;
    end else if (match.lh_short) begin
      gap_shift = {shift_r[CODE_WIDTH-2:0], 1'b0};
      gap_count = cnt_sat1;
    end else begin
      gap_shift = shift_r;
      gap_count = count_r;
    end
  end

  always_comb begin
    phase_nxt     = pwmook_pkg::PH_IDLE;
    last_high_nxt = last_high_r;
    shift_nxt     = shift_r;
    count_nxt     = count_r;
    emit          = 1'b0;
    case (phase_r)
      pwmook_pkg::PH_HIGH: begin
        if (level_r) begin
          last_high_nxt = dur_r;
          phase_nxt     = pwmook_pkg::PH_LOW;
        end
      end
      pwmook_pkg::PH_LOW: begin
        if (level_r) begin
          phase_nxt = pwmook_pkg::PH_IDLE;
        end else if (match.lh_long && match.dur_short) begin
          shift_nxt = {shift_r[CODE_WIDTH-2:0], 1'b1};
          count_nxt = cnt_sat1;
          phase_nxt = pwmook_pkg::PH_HIGH;
        end else if (match.lh_short && match.dur_long) begin
          shift_nxt = {shift_r[CODE_WIDTH-2:0], 1'b0};
          count_nxt = cnt_sat1;
          phase_nxt = pwmook_pkg::PH_HIGH;
        end else if (match.dur_gap) begin
          emit      = (gap_count == frame_bits_r);
          shift_nxt = '0;
          count_nxt = '0;
        end
      end
      default: begin
        // idle, and the unused code handled as idle
        if (!level_r && match.dur_gap) begin
          shift_nxt = '0;
          count_nxt = '0;
          phase_nxt = pwmook_pkg::PH_HIGH;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= pwmook_pkg::PH_IDLE;
      last_high_r <= '0;
      shift_r     <= '0;
      count_r     <= '0;
    end else if (work) begin
      phase_r     <= phase_nxt;
      last_high_r <= last_high_nxt;
      shift_r     <= shift_nxt;
      count_r     <= count_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (work && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (work && emit) begin
      code_r <= gap_shift;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.code  = pwmook_pkg::OUT_W'(code_r);

endmodule
